### rtl/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
package bba_pkg;

	localparam int WORD_W  = 64;
	localparam int BIT_W   = 6;
	localparam int BLOCK_W = 12;
	localparam int WIU_W   = 7;
	localparam int OP_W    = 2;
	localparam int STEP_W  = 3;

	localparam logic [WIU_W-1:0]  WIU_RESET = 7'd64;
	localparam logic [STEP_W-1:0] FIND_LAST = 3'd5;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_RELEASE = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_REL_RD,
		ST_REL_WR
	} state_t;

endpackage

### rtl/bitmap_block_allocator.sv
// First-fit block allocator over a bitmap of 64-bit used words.
// Load writes one word and release clears one bit by read-modify-write, both only inside the map;
// allocate scans from word 0 and reports full when no word below words_in_use (capped at the
// map size) has a clear bit, or when it is zero. One item at a time; busy stays high until it ends.
// The scan reads one bitmap word per cycle through the single memory read port, then a
// 6-step binary search unit finds the lowest clear bit. Reset: all words read as free through
// per-word valid bits (no clearing pass), words_in_use returns to 64. Results cannot be stalled.
module bitmap_block_allocator #(
	parameter int MAP_WORDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bba_pkg::WIU_W-1:0]    cfg_wr_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [bba_pkg::OP_W-1:0]     operation,
	input  logic [bba_pkg::BIT_W-1:0]    word_index,
	input  logic [bba_pkg::WORD_W-1:0]   word_data,
	input  logic [bba_pkg::BLOCK_W-1:0]  block_number,
	output logic                         done,
	output logic [bba_pkg::BLOCK_W-1:0]  allocated_block,
	output logic                         status
);
	import bba_pkg::*;

	// words past index 126 can never be reached by a 7-bit scan length
	localparam int MaxWords = 127;
	localparam int NWORDS   = (MAP_WORDS < MaxWords) ? MAP_WORDS : MaxWords;
	localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [WIU_W-1:0] NWORDS_V = WIU_W'(NWORDS);

	state_t state_q, state_d;

	logic [WIU_W-1:0]  wiu_q;
	logic [WIU_W-1:0]  limit_q;
	logic [WIU_W-1:0]  addr_q;
	logic [WIU_W-1:0]  idx_s1;
	logic [WIU_W-1:0]  fidx_q;
	logic              pend_s1;
	logic [WORD_W-1:0] mem [NWORDS];
	logic [NWORDS-1:0] valid_q;
	logic [WORD_W-1:0] rd_data_s1;
	logic              rd_vld_s1;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] win_q;
	logic [BIT_W-1:0]  pos_q;
	logic [STEP_W-1:0] step_q;
	logic [AW-1:0]     rel_word_q;
	logic [BIT_W-1:0]  rel_bit_q;
	logic              done_q;
	logic [BLOCK_W-1:0] block_q;
	logic              status_q;

	logic               done_d;
	logic [BLOCK_W-1:0] block_d;
	logic               status_d;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [WORD_W-1:0]  wr_data;
	logic               found;
	logic [WORD_W-1:0]  word_s1;
	logic               word_full;
	logic [WIU_W-1:0]   limit_start;
	logic               load_in_map;
	logic               rel_in_map;
	logic               low_zero;
	logic [WORD_W-1:0]  win_sh;
	logic [BIT_W-1:0]   step_size;
	logic [WORD_W-1:0]  win_next;
	logic [BIT_W-1:0]   pos_next;

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign allocated_block = block_q;
	assign status          = status_q;

	// word as stored; never-written words read as free
	assign word_s1     = rd_vld_s1 ? rd_data_s1 : '0;
	assign word_full   = &word_s1;
	assign limit_start = (wiu_q < NWORDS_V) ? wiu_q : NWORDS_V;
	assign load_in_map = (WIU_W'(word_index) < NWORDS_V);
	assign rel_in_map  = (WIU_W'(block_number[BLOCK_W-1:BIT_W]) < NWORDS_V);

	// binary search step: drop the low half of the window if it has no clear bit
	always_comb begin
		case (step_q)
			3'd0: begin
				low_zero  = (win_q[31:0] == '0);
				win_sh    = win_q >> 32;
				step_size = 6'd32;
			end
			3'd1: begin
				low_zero  = (win_q[15:0] == '0);
				win_sh    = win_q >> 16;
				step_size = 6'd16;
			end
			3'd2: begin
				low_zero  = (win_q[7:0] == '0);
				win_sh    = win_q >> 8;
				step_size = 6'd8;
			end
			3'd3: begin
				low_zero  = (win_q[3:0] == '0);
				win_sh    = win_q >> 4;
				step_size = 6'd4;
			end
			3'd4: begin
				low_zero  = (win_q[1:0] == '0);
				win_sh    = win_q >> 2;
				step_size = 6'd2;
			end
			default: begin
				low_zero  = ~win_q[0];
				win_sh    = win_q >> 1;
				step_size = 6'd1;
			end
		endcase
		win_next = low_zero ? win_sh : win_q;
		pos_next = low_zero ? (pos_q + step_size) : pos_q;
	end

	// sequencer: next state, memory port control and result
	always_comb begin
		state_d  = state_q;
		done_d   = 1'b0;
		block_d  = '0;
		status_d = STATUS_DONE;
		rd_en    = 1'b0;
		rd_addr  = addr_q[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = AW'(word_index);
		wr_data  = word_data;
		found    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_LOAD: begin
							wr_en  = load_in_map;
							done_d = 1'b1;
						end
						OP_ALLOC: begin
							if (limit_start == '0) begin
								done_d   = 1'b1;
								status_d = STATUS_FULL;
							end else begin
								state_d = ST_SCAN;
							end
						end
						OP_RELEASE: begin
							if (rel_in_map) begin
								state_d = ST_REL_RD;
							end else begin
								done_d = 1'b1;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// issue word addr_q, test the word issued last cycle
				rd_en = (addr_q < limit_q);
				if (pend_s1 && !word_full) begin
					found   = 1'b1;
					state_d = ST_FIND;
				end else if (pend_s1 && (idx_s1 == limit_q - 1'b1)) begin
					done_d   = 1'b1;
					status_d = STATUS_FULL;
					state_d  = ST_IDLE;
				end
			end
			ST_FIND: begin
				if (step_q == FIND_LAST) begin
					wr_en   = 1'b1;
					wr_addr = fidx_q[AW-1:0];
					wr_data = word_q | (WORD_W'(1) << pos_next);
					done_d  = 1'b1;
					block_d = {fidx_q[BIT_W-1:0], pos_next};
					state_d = ST_IDLE;
				end
			end
			ST_REL_RD: begin
				rd_en   = 1'b1;
				rd_addr = rel_word_q;
				state_d = ST_REL_WR;
			end
			ST_REL_WR: begin
				wr_en   = 1'b1;
				wr_addr = rel_word_q;
				wr_data = word_s1 & ~(WORD_W'(1) << rel_bit_q);
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wiu_q   <= WIU_RESET;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			pend_s1 <= (state_q == ST_SCAN) && rd_en && (state_d == ST_SCAN);
			if (cfg_wr_en) begin
				wiu_q <= cfg_wr_data;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// bitmap memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_vld_s1  <= valid_q[rd_addr];
		end
	end

	// scan, search and release datapath
	always_ff @(posedge clk) begin
		block_q  <= block_d;
		status_q <= status_d;
		if ((state_q == ST_IDLE) && start) begin
			limit_q    <= limit_start;
			addr_q     <= '0;
			rel_word_q <= AW'(block_number[BLOCK_W-1:BIT_W]);
			rel_bit_q  <= block_number[BIT_W-1:0];
		end
		if ((state_q == ST_SCAN) && rd_en) begin
			addr_q <= addr_q + 1'b1;
			idx_s1 <= addr_q;
		end
		if (found) begin
			word_q <= word_s1;
			win_q  <= ~word_s1;
			pos_q  <= '0;
			step_q <= '0;
			fidx_q <= idx_s1;
		end else if (state_q == ST_FIND) begin
			win_q  <= win_next;
			pos_q  <= pos_next;
			step_q <= step_q + 1'b1;
		end
	end

endmodule

### rtl/bba_checker.sv
// Port-level checks for the bitmap block allocator, bound to the top level.
module bba_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic [bba_pkg::OP_W-1:0]     operation,
	input logic                         done,
	input logic [bba_pkg::BLOCK_W-1:0]  allocated_block,
	input logic                         status
);
	import bba_pkg::*;

	// a full map never grants a block
	a_full_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_FULL) |-> (allocated_block == '0))
		else $error("full status with nonzero block");

	// a load word finishes on the next cycle with a plain done
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (operation == OP_LOAD)
		|=> done && (status == STATUS_DONE) && (allocated_block == '0))
		else $error("load did not complete in one cycle");

	// the block only goes busy after taking a command
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without start");

	// a result is only shown once the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.operation       (operation),
	.done            (done),
	.allocated_block (allocated_block),
	.status          (status)
);
